FILE: hw/rtl/pidc_pkg.sv
package pidc_pkg;

    typedef enum logic [2:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_OUT_LIMITS  = 3'd3,
        CFG_INT_WINDOW  = 3'd4,
        CFG_DAMP_WINDOW = 3'd5,
        CFG_ROLLOVER    = 3'd6,
        CFG_DEADZONE    = 3'd7
    } t_cfg_idx;

    localparam logic [23:0] GAIN_P_RST     = 24'h010000;
    localparam logic [63:0] OUT_LIMITS_RST = 64'h7FFF_FFFF_8000_0000;
    localparam logic [47:0] INT_WINDOW_RST = 48'h7FFF_FF80_0000;

    localparam logic signed [47:0] INT_MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] INT_MIN48 = 48'sh8000_0000_0000;

    typedef struct packed {
        logic signed [23:0] gain_p;
        logic signed [23:0] gain_i;
        logic signed [23:0] gain_d;
        logic [63:0]        out_limits;
        logic [47:0]        int_window;
        logic [47:0]        damp_window;
        logic [47:0]        rollover;
        logic [47:0]        deadzone;
    } t_cfg;

    // error stage result: error after rollover/dampening, derivative term, integral
    typedef struct packed {
        logic signed [24:0] err;
        logic signed [25:0] diff;
        logic signed [47:0] integ;
    } t_err_res;

endpackage

FILE: hw/rtl/pidc_state.sv
module pidc_state import pidc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_setpoint,
    input  logic signed [15:0] i_measured,
    output t_err_res           o_res
);

    logic               r_seeded;
    logic signed [24:0] r_prev;
    logic signed [47:0] r_integ;

    logic signed [16:0] e_raw;
    logic signed [24:0] e_raw25;
    logic [16:0]        mag;
    logic signed [23:0] rr_hi, rr_lo, iw_hi, iw_lo, dw_hi, dw_lo;
    logic signed [24:0] span;
    logic               wrap;
    logic signed [24:0] e_roll, e_sel, e_fin, prev_use;
    logic               in_iw, in_dw;
    logic signed [48:0] isum;
    logic signed [47:0] integ_add, n_integ;

    always_comb begin
        e_raw   = 17'($signed({i_setpoint[15], i_setpoint}) - $signed({i_measured[15], i_measured}));
        e_raw25 = 25'(e_raw);
        mag     = e_raw[16] ? 17'(-e_raw) : e_raw;

        rr_hi = $signed(i_cfg.rollover[47:24]);
        rr_lo = $signed(i_cfg.rollover[23:0]);
        span  = 25'(rr_hi) - 25'(rr_lo);
        wrap  = (i_cfg.rollover != '0) &&
                ($signed({8'b0, mag, 1'b0}) > $signed({span[24], span}));
        e_roll = (e_raw > 17'sd0) ? e_raw25 - 25'(rr_hi) : e_raw25 + 25'(rr_hi);
        e_sel  = wrap ? e_roll : e_raw25;

        iw_hi = $signed(i_cfg.int_window[47:24]);
        iw_lo = $signed(i_cfg.int_window[23:0]);
        in_iw = (e_sel > 25'(iw_lo)) && (e_sel < 25'(iw_hi));
        isum  = 49'(r_integ) + 49'(e_sel);
        if (isum[48] != isum[47]) begin
            integ_add = isum[48] ? INT_MIN48 : INT_MAX48;
        end else begin
            integ_add = isum[47:0];
        end

        dw_hi = $signed(i_cfg.damp_window[47:24]);
        dw_lo = $signed(i_cfg.damp_window[23:0]);
        in_dw = (i_cfg.damp_window != '0) && (e_sel > 25'(dw_lo)) && (e_sel < 25'(dw_hi));

        n_integ = in_iw ? integ_add : r_integ;
        e_fin   = e_sel;
        if (in_dw) begin
            n_integ = '0;
            e_fin   = '0;
        end

        prev_use = r_seeded ? r_prev : e_raw25;

        o_res.err   = e_fin;
        o_res.diff  = 26'(e_fin) - 26'(prev_use);
        o_res.integ = n_integ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_prev   <= '0;
            r_integ  <= '0;
        end else if (i_en) begin
            r_seeded <= 1'b1;
            r_prev   <= e_fin;
            r_integ  <= n_integ;
        end
    end

endmodule

FILE: hw/rtl/pid_controller_with_options_top.sv
// Channel   | Dir | Signals                          | Contents (low bit up)
// s_axis    | in  | tvalid tready tdata[31:0]        | setpoint[15:0], measured[31:16]
// m_axis    | out | tvalid tready tdata[63:0]        | drive[31:0], error_now[56:32], 0
// cfg       | in  | valid ready index[2:0] data[63:0]| register write, ready always high
//
// One sample per cycle unless m_axis stalls; stages: input, error, product, sum, out.
// Integral and previous error update as a sample leaves the first stage, so
// consecutive samples see each other's state with no gap.
// Reset is synchronous: state cleared, registers to defaults, pipeline empty.
// Bubbles collapse on an output stall; s_axis_tready falls only when all
// stages and the output register are full.
module pid_controller_with_options_top import pidc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // setpoint[15:0], measured[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // drive[31:0], error_now[56:32], zero[63:57]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg r_cfg;

    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic go_out, go4, go3, go2, go1;

    logic signed [15:0] r_sp, r_ms;
    t_err_res           r_s2, s2_next;

    logic signed [24:0] r_e3;
    logic signed [48:0] r_prod_p;
    logic signed [49:0] r_prod_d;
    logic signed [48:0] r_prod_il;
    logic signed [47:0] r_prod_ih;

    logic signed [24:0] r_e4;
    logic signed [31:0] r_drv4;

    logic signed [31:0] r_drive;
    logic signed [24:0] r_err_out;

    logic signed [73:0] sum;
    logic signed [57:0] q;
    logic signed [31:0] n_drv4;

    logic signed [31:0] lim_hi, lim_lo, d_hi, d_cl, dz;
    logic signed [32:0] dsum;
    logic signed [31:0] n_drive;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p      <= GAIN_P_RST;
            r_cfg.gain_i      <= '0;
            r_cfg.gain_d      <= '0;
            r_cfg.out_limits  <= OUT_LIMITS_RST;
            r_cfg.int_window  <= INT_WINDOW_RST;
            r_cfg.damp_window <= '0;
            r_cfg.rollover    <= '0;
            r_cfg.deadzone    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:      r_cfg.gain_p      <= i_cfg_data[23:0];
                CFG_GAIN_I:      r_cfg.gain_i      <= i_cfg_data[23:0];
                CFG_GAIN_D:      r_cfg.gain_d      <= i_cfg_data[23:0];
                CFG_OUT_LIMITS:  r_cfg.out_limits  <= i_cfg_data;
                CFG_INT_WINDOW:  r_cfg.int_window  <= i_cfg_data[47:0];
                CFG_DAMP_WINDOW: r_cfg.damp_window <= i_cfg_data[47:0];
                CFG_ROLLOVER:    r_cfg.rollover    <= i_cfg_data[47:0];
                CFG_DEADZONE:    r_cfg.deadzone    <= i_cfg_data[47:0];
            endcase
        end
    end

    // per-stage load enables; a stage loads when empty or draining
    assign go_out        = !r_ov || m_axis_tready;
    assign go4           = !r_v4 || go_out;
    assign go3           = !r_v3 || go4;
    assign go2           = !r_v2 || go3;
    assign go1           = !r_v1 || go2;
    assign s_axis_tready = go1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (go1)    r_v1 <= s_axis_tvalid;
            if (go2)    r_v2 <= r_v1;
            if (go3)    r_v3 <= r_v2;
            if (go4)    r_v4 <= r_v3;
            if (go_out) r_ov <= r_v4;
        end
    end

    pidc_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (r_v1 && go2),
        .i_cfg      (r_cfg),
        .i_setpoint (r_sp),
        .i_measured (r_ms),
        .o_res      (s2_next)
    );

    // partial sum and saturation
    always_comb begin
        sum = {{2{r_prod_ih[47]}}, r_prod_ih, 24'b0}
            + 74'(r_prod_il) + 74'(r_prod_p) + 74'(r_prod_d);
        q   = sum[73:16];
        if (q > 58'sh7FFF_FFFF) begin
            n_drv4 = 32'sh7FFF_FFFF;
        end else if (q < -58'sh8000_0000) begin
            n_drv4 = 32'sh8000_0000;
        end else begin
            n_drv4 = q[31:0];
        end
    end

    // clamp, then deadzone by error sign with saturation; zero error gives zero drive
    always_comb begin
        lim_hi = $signed(r_cfg.out_limits[63:32]);
        lim_lo = $signed(r_cfg.out_limits[31:0]);
        d_hi   = (r_drv4 > lim_hi) ? lim_hi : r_drv4;
        d_cl   = (d_hi < lim_lo) ? lim_lo : d_hi;
        dz     = r_e4[24] ? 32'($signed(r_cfg.deadzone[23:0]))
                          : 32'($signed(r_cfg.deadzone[47:24]));
        dsum   = 33'(d_cl) + 33'(dz);
        if (dsum[32] != dsum[31]) begin
            n_drive = dsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_drive = dsum[31:0];
        end
        if (r_e4 == '0) begin
            n_drive = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go1) begin
            r_sp <= $signed(s_axis_tdata[15:0]);
            r_ms <= $signed(s_axis_tdata[31:16]);
        end
        if (go2) begin
            r_s2 <= s2_next;
        end
        if (go3) begin
            r_e3      <= r_s2.err;
            r_prod_p  <= 49'(r_s2.err) * 49'(r_cfg.gain_p);
            r_prod_d  <= 50'(r_s2.diff) * 50'(r_cfg.gain_d);
            r_prod_il <= 49'($signed({1'b0, r_s2.integ[23:0]})) * 49'(r_cfg.gain_i);
            r_prod_ih <= 48'($signed(r_s2.integ[47:24])) * 48'(r_cfg.gain_i);
        end
        if (go4) begin
            r_e4   <= r_e3;
            r_drv4 <= n_drv4;
        end
        if (go_out) begin
            r_drive   <= n_drive;
            r_err_out <= r_e4;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'b0, r_err_out, r_drive};

endmodule

FILE: hw/rtl/pidc_checker.sv
module pidc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("m_axis_tdata changed while stalled");

    a_zero_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[56:32] == 25'd0) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("nonzero drive on zero error");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind pid_controller_with_options_top pidc_checker u_pidc_checker (.*);
